// ----- rtl/pal_pkg.sv -----
`default_nettype none

package pal_pkg;

    localparam int LIST_DEPTH = 128;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int DATA_W     = 32;
    localparam int WIDE_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/pal_if.sv -----
`default_nettype none

interface pal_in_if
    import pal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
    modport monitor (input valid, input ready, input mode, input position, input value);
endinterface

interface pal_out_if
    import pal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         entry_count;

    modport source (output valid, output status, output found_position, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_position, input read_value,
                    input entry_count, output ready);
    modport monitor (input valid, input ready, input status, input found_position,
                     input read_value, input entry_count);
endinterface

`default_nettype wire

// ----- rtl/pal_mem.sv -----
`default_nettype none

module pal_mem
    import pal_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_req_t          req,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0] mem_reg [LIST_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/pal_seq.sv -----
`default_nettype none

module pal_seq
    import pal_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    pal_in_if.sink            in_ch,
    pal_out_if.source         out_ch,
    output mem_req_t          req,
    input  wire logic [DATA_W-1:0] rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    status_t           stat_reg, stat_next;
    logic [POS_W-1:0]  found_reg, found_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [POS_W-1:0]  out_found_reg, out_found_next;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic [POS_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [WIDE_W-1:0] pos_x;
    logic [WIDE_W-1:0] cnt_x;
    logic              issue;

    assign pos_x = WIDE_W'(in_ch.position);
    assign cnt_x = WIDE_W'(cnt_reg);
    assign issue = (left_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        pend_next       = 1'b0;
        pend_addr_next  = addr_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        rd_next         = rd_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_rd_next     = out_rd_reg;
        out_cnt_next    = out_cnt_reg;
        req.we          = 1'b0;
        req.waddr       = '0;
        req.wdata       = val_reg;
        req.raddr       = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next  = mode_t'(in_ch.mode);
                    pos_next   = in_ch.position;
                    val_next   = in_ch.value;
                    stat_next  = ST_OK;
                    found_next = '0;
                    rd_next    = '0;
                    left_next  = '0;
                    addr_next  = '0;
                    state_next = S_WALK;
                    unique case (mode_t'(in_ch.mode))
                        MODE_INSERT:
                        begin
                            if (cnt_x == WIDE_W'(LIST_DEPTH))
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (pos_x == '0 || pos_x > cnt_x + WIDE_W'(1))
                            begin
                                stat_next  = ST_BADPOS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // move entries pos-1..cnt-1 up, walking down from the top
                                left_next = CNT_W'(cnt_x - pos_x + WIDE_W'(1));
                                addr_next = IDX_W'(cnt_x - WIDE_W'(1));
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_x == '0 || pos_x > cnt_x)
                            begin
                                stat_next  = ST_BADPOS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                left_next = CNT_W'(cnt_x - pos_x);
                                addr_next = IDX_W'(pos_x);
                            end
                        end
                        MODE_SEARCH:
                        begin
                            left_next = cnt_reg;
                        end
                        MODE_READ:
                        begin
                            if (pos_x == '0 || pos_x > cnt_x)
                            begin
                                stat_next  = ST_BADPOS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                left_next = CNT_W'(1);
                                addr_next = IDX_W'(pos_x - WIDE_W'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_WALK:
            begin
                // one read issued per cycle, its data handled the cycle after
                if (issue)
                begin
                    addr_next = (mode_reg == MODE_INSERT) ? addr_reg - IDX_W'(1)
                                                          : addr_reg + IDX_W'(1);
                    left_next = left_reg - CNT_W'(1);
                end
                pend_next      = issue;
                pend_addr_next = addr_reg;

                if (pend_reg)
                begin
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = pend_addr_reg + IDX_W'(1);
                            req.wdata = rdata;
                        end
                        MODE_DELETE:
                        begin
                            req.we    = 1'b1;
                            req.waddr = pend_addr_reg - IDX_W'(1);
                            req.wdata = rdata;
                        end
                        MODE_SEARCH:
                        begin
                            // ascending walk, so the last hit wins
                            if (rdata == val_reg)
                            begin
                                found_next = POS_W'(pend_addr_reg) + POS_W'(1);
                            end
                        end
                        MODE_READ:
                        begin
                            rd_next = rdata;
                        end
                        default: ;
                    endcase
                end
                else if (!issue)
                begin
                    unique case (mode_reg)
                        MODE_INSERT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = IDX_W'(pos_reg - POS_W'(1));
                            req.wdata = val_reg;
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                        MODE_DELETE:
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        MODE_SEARCH:
                        begin
                            if (found_reg == '0)
                            begin
                                stat_next = ST_NOTFOUND;
                            end
                        end
                        MODE_READ: ;
                        default: ;
                    endcase
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_found_next  = found_reg;
                    out_rd_next     = rd_reg;
                    out_cnt_next    = POS_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            left_reg       <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_INSERT;
            pos_reg        <= '0;
            val_reg        <= '0;
            addr_reg       <= '0;
            pend_addr_reg  <= '0;
            stat_reg       <= ST_OK;
            found_reg      <= '0;
            rd_reg         <= '0;
            out_status_reg <= ST_OK;
            out_found_reg  <= '0;
            out_rd_reg     <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            left_reg       <= left_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            addr_reg       <= addr_next;
            pend_addr_reg  <= pend_addr_next;
            stat_reg       <= stat_next;
            found_reg      <= found_next;
            rd_reg         <= rd_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_rd_reg     <= out_rd_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.found_position = out_found_reg;
    assign out_ch.read_value     = out_rd_reg;
    assign out_ch.entry_count    = out_cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/positional_array_list_top.sv -----
// positional array list: ordered list of up to 128 signed 32-bit entries
// in_ch carries one command word: mode (insert, delete, search, read),
// 1-based position and value. out_ch returns one result word per command:
// status, found_position, read_value and the entry count after the command.
// entries live in a single-port-read, single-port-write ram; a sequencer
// walks it one entry per cycle through one comparator.
// insert moves count-position+1 entries, delete count-position, search reads
// all count entries, read one entry. the sequencer registers the command,
// walks its entries, finishes the command and loads the result word into
// the output register from its response state; a rejected command skips
// the walk. in_ch.ready returns with the result.
// in_ch.ready is high only while the sequencer is idle, one command at a time.
// the result sits in an output register; the next command is accepted while
// it waits, but its own result holds until out_ch.ready takes the old word.
// reset (rst_n low, async) empties the list and drops any pending result;
// ram contents are not cleared and need not be.
`default_nettype none

module positional_array_list_top
    import pal_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pal_in_if.sink     in_ch,
    pal_out_if.source  out_ch
);

    mem_req_t          req;
    logic [DATA_W-1:0] rdata;

    pal_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .req    (req),
        .rdata  (rdata)
    );

    pal_mem u_mem (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/pal_checker.sv -----
`default_nettype none

module pal_checker
    import pal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic [1:0]        out_status,
    input  wire logic [POS_W-1:0]  out_found,
    input  wire logic [DATA_W-1:0] out_read,
    input  wire logic [POS_W-1:0]  out_count
);

    // one command at a time: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("command accepted while previous one in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status == ST_FULL) |-> out_count == POS_W'(LIST_DEPTH))
        else $error("list full reported below depth");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_found != '0) |->
        (out_status == ST_OK && out_found <= out_count))
        else $error("found position outside live entries");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status == ST_NOTFOUND || out_status == ST_BADPOS ||
                       out_status == ST_FULL)) |->
        (out_found == '0 && out_read == '0))
        else $error("failed command returned data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= POS_W'(LIST_DEPTH))
        else $error("entry count above depth");

endmodule

bind positional_array_list_top pal_checker u_pal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_found  (out_ch.found_position),
    .out_read   (out_ch.read_value),
    .out_count  (out_ch.entry_count)
);

`default_nettype wire

// ----- tb/pal_list_checker.sv -----
`timescale 1ns / 100ps

module pal_list_checker
    import pal_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pal_in_if.monitor   in_ch,
    pal_out_if.monitor  out_ch,
    output int          fail_count,
    output int          pending_count,
    output int          list_size
);

    typedef struct {
        status_t                  status;
        logic [POS_W-1:0]         found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         entry_count;
    } result_word_t;

    logic signed [DATA_W-1:0] list_shadow[$];
    result_word_t             pending_results[$];
    result_word_t             expected_word;

    // updates the shadow list and returns the result word the command must produce
    function automatic result_word_t apply_command(mode_t m, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        result_word_t r;
        int p;
        int n;
        p = int'(pos);
        n = list_shadow.size();
        r.status         = ST_OK;
        r.found_position = '0;
        r.read_value     = '0;
        case (m)
            MODE_INSERT:
            begin
                // full is checked ahead of the position
                if (n >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (p < 1 || p > n + 1)
                    r.status = ST_BADPOS;
                else
                    list_shadow.insert(p - 1, val);
            end
            MODE_DELETE:
            begin
                if (p < 1 || p > n)
                    r.status = ST_BADPOS;
                else
                    list_shadow.delete(p - 1);
            end
            MODE_SEARCH:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (list_shadow[i] == val)
                        r.found_position = POS_W'(i + 1);
                end
                if (r.found_position == '0)
                    r.status = ST_NOTFOUND;
            end
            default:
            begin
                if (p < 1 || p > n)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_shadow[p - 1];
            end
        endcase
        r.entry_count = POS_W'(list_shadow.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_shadow.delete();
            pending_results.delete();
            fail_count    = 0;
            pending_count = 0;
            list_size     = 0;
        end
        else
        begin
            // result side first, a word accepted now cannot belong to this edge's command
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing outstanding: status %0d found %0d read %0d count %0d",
                                 $time, out_ch.status, out_ch.found_position,
                                 out_ch.read_value, out_ch.entry_count);
                end
                else
                begin
                    expected_word = pending_results.pop_front();
                    if (out_ch.status !== expected_word.status
                        || out_ch.found_position !== expected_word.found_position
                        || out_ch.read_value !== expected_word.read_value
                        || out_ch.entry_count !== expected_word.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp status %0d found %0d read %0d count %0d, got status %0d found %0d read %0d count %0d",
                                     $time, expected_word.status, expected_word.found_position,
                                     expected_word.read_value, expected_word.entry_count,
                                     out_ch.status, out_ch.found_position,
                                     out_ch.read_value, out_ch.entry_count);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_results.push_back(apply_command(mode_t'(in_ch.mode), in_ch.position,
                                                        in_ch.value));
            pending_count = pending_results.size();
            list_size     = list_shadow.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import pal_pkg::*;

    localparam int PHASE_WORDS  = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   fail_count;
    int   pending_count;
    int   list_size;
    int   send_idle_pct  = 25;
    int   recv_idle_pct  = 54;
    logic rx_hold        = 1'b0;
    logic long_stall_req = 1'b0;
    logic filling        = 1'b1;

    pal_in_if  cmd_ch();
    pal_out_if rsp_ch();

    positional_array_list_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (rsp_ch)
    );

    pal_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (cmd_ch),
        .out_ch        (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .list_size     (list_size)
    );

    always #10 clk = ~clk;

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (long_stall_req);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #50ms;
        $display("FAIL positional_array_list_top");
        $finish;
    end

    // small pool so searches hit and duplicates show up
    function automatic logic signed [DATA_W-1:0] pool_value(int idx);
        case (idx)
            0:       return 32'sd0;
            1:       return 32'sd1;
            2:       return -32'sd1;
            3:       return 32'sd7;
            4:       return -32'sd100;
            5:       return 32'h7fff_ffff;
            6:       return 32'h8000_0000;
            default: return 32'sd42;
        endcase
    endfunction

    // called at a falling edge; returns right after the word is accepted
    task automatic drive_word(mode_t m, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic send_word(mode_t m, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
        @(negedge clk);
        drive_word(m, pos, val);
    endtask

    task automatic send_random_word();
        int                       cnt;
        int                       roll;
        mode_t                    m;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        @(negedge clk);
        cnt = list_size;
        // fill to the top, linger while full, then drain back down
        if (cnt >= LIST_DEPTH && $urandom_range(7) == 0)
            filling = 1'b0;
        else if (cnt == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
            m = (roll < 55) ? MODE_INSERT : (roll < 70) ? MODE_DELETE :
                (roll < 85) ? MODE_SEARCH : MODE_READ;
        else
            m = (roll < 15) ? MODE_INSERT : (roll < 65) ? MODE_DELETE :
                (roll < 82) ? MODE_SEARCH : MODE_READ;
        if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(255));
        else if (m == MODE_INSERT)
            pos = POS_W'($urandom_range(cnt + 1, 1));
        else if (cnt == 0)
            pos = 8'd1;
        else
            pos = POS_W'($urandom_range(cnt, 1));
        if ($urandom_range(9) < 6)
            val = pool_value($urandom_range(7));
        else
            val = $urandom;
        drive_word(m, pos, val);
    endtask

    initial
    begin
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_INSERT;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list, position zero and one past the end
        send_word(MODE_READ,   8'd1, 32'sd0);
        send_word(MODE_DELETE, 8'd1, 32'sd0);
        send_word(MODE_SEARCH, 8'd0, 32'sd0);
        send_word(MODE_INSERT, 8'd0, 32'sd5);
        send_word(MODE_INSERT, 8'd2, 32'sd5);
        // build min, 0, max, -1, -1 through front, middle and end inserts
        send_word(MODE_INSERT, 8'd1, 32'h7fff_ffff);
        send_word(MODE_INSERT, 8'd1, 32'h8000_0000);
        send_word(MODE_INSERT, 8'd3, -32'sd1);
        send_word(MODE_INSERT, 8'd2, 32'sd0);
        send_word(MODE_INSERT, 8'd5, -32'sd1);
        send_word(MODE_SEARCH, 8'd0, -32'sd1);
        send_word(MODE_SEARCH, 8'd0, 32'h8000_0000);
        send_word(MODE_SEARCH, 8'd0, 32'sd77);
        send_word(MODE_READ,   8'd0, 32'sd0);
        send_word(MODE_READ,   8'd1, 32'sd0);
        send_word(MODE_READ,   8'd5, 32'sd0);
        send_word(MODE_READ,   8'd6, 32'sd0);
        send_word(MODE_READ,   8'd255, 32'hffff_ffff);
        send_word(MODE_DELETE, 8'd6, 32'sd0);
        send_word(MODE_DELETE, 8'd0, 32'sd0);
        send_word(MODE_DELETE, 8'd1, 32'sd0);
        send_word(MODE_DELETE, 8'd4, 32'sd0);
        send_word(MODE_SEARCH, 8'd0, 32'h7fff_ffff);
        send_word(MODE_READ,   8'd128, 32'sd0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 25 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 0 && n == PHASE_WORDS / 2)
                    long_stall_req = 1'b1;
                send_random_word();
            end
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS positional_array_list_top");
        else
            $display("FAIL positional_array_list_top");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/pal_mem.sv
rtl/pal_seq.sv
rtl/positional_array_list_top.sv
rtl/pal_checker.sv
tb/pal_list_checker.sv
tb/tb_top.sv
